>>> hw/rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator package
// Command codes, fit policy codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int CMD_W   = 2;
    localparam int BIDX_W  = 5;
    localparam int SIZE_W  = 16;
    localparam int GIDX_W  = 5;
    localparam int POL_W   = 2;
    localparam int COUNT_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [POL_W-1:0]  policy_t;
    typedef logic [SIZE_W-1:0] size_t;

    localparam cmd_t CMD_LOAD  = 2'd0;
    localparam cmd_t CMD_ALLOC = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    localparam policy_t POLICY_FIRST = 2'd0;
    localparam policy_t POLICY_BEST  = 2'd1;
    localparam policy_t POLICY_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

endpackage

>>> hw/rtl/fpfa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator
// Grants free partitions from a loaded size table by first, best or worst fit.
// ----------------------------------------------------------------------------
// A request scans entries 0 to min(block_count, NUM_BLOCKS) - 1, one entry per
// cycle, then passes through ST_FINISH to its result; an empty range reads no entry.
// Loads and clears are taken back to back and produce no result.
// A new item is taken only in ST_IDLE, after a request has left ST_FINISH, and a
// request waits in ST_FINISH while an earlier result is still held by m_tready.
// Reset clears the used flags, the registers and the output; sizes are kept.
module fixed_partition_fit_allocator #(
    parameter int NUM_BLOCKS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpfa_pkg::S_TDATA_W-1:0]    s_tdata,  // block_index[4:0], size_value[20:5]
    input  logic [fpfa_pkg::CMD_W-1:0]        s_tuser,  // command[1:0]
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fpfa_pkg::M_TDATA_W-1:0]    m_tdata,  // granted_index[4:0]
    output logic                              m_tuser   // granted[0]
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                      state_reg, state_next;
    fpfa_pkg::policy_t               fit_policy_reg, fit_policy_next;
    logic [fpfa_pkg::COUNT_W-1:0]    block_count_reg, block_count_next;
    logic [NUM_BLOCKS-1:0]           in_use_reg, in_use_next;
    logic [CNT_W-1:0]                raddr_reg, raddr_next;
    logic                            rvalid_reg, rvalid_next;
    logic                            found_reg, found_next;
    logic                            out_valid_reg, out_valid_next;

    fpfa_pkg::size_t                 req_size_reg, req_size_next;
    logic [CNT_W-1:0]                lim_reg, lim_next;
    logic [IDX_W-1:0]                ridx_reg, ridx_next;
    logic                            rused_reg, rused_next;
    logic [IDX_W-1:0]                pick_reg, pick_next;
    fpfa_pkg::size_t                 pick_size_reg, pick_size_next;
    logic                            out_granted_reg, out_granted_next;
    logic [fpfa_pkg::GIDX_W-1:0]     out_index_reg, out_index_next;

    fpfa_pkg::cmd_t                  in_cmd;
    logic [fpfa_pkg::BIDX_W-1:0]     in_bidx;
    fpfa_pkg::size_t                 in_size;
    logic                            in_xfer;
    logic                            idx_ok;
    logic [IDX_W-1:0]                load_addr;
    logic                            ram_wr_en;
    logic                            ram_rd_en;
    fpfa_pkg::size_t                 ram_rd_data;
    logic                            fits;
    logic                            take;

    assign in_cmd    = s_tuser;
    assign in_bidx   = s_tdata[fpfa_pkg::BIDX_W-1:0];
    assign in_size   = s_tdata[fpfa_pkg::BIDX_W +: fpfa_pkg::SIZE_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign idx_ok    = (32'(in_bidx) < NUM_BLOCKS);
    assign load_addr = IDX_W'(in_bidx);
    assign ram_wr_en = in_xfer && (in_cmd == fpfa_pkg::CMD_LOAD) && idx_ok;
    assign ram_rd_en = (state_reg == ST_SCAN) && (raddr_reg < lim_reg);
    assign cfg_ready = 1'b1;

    fpfa_ram #(
        .WIDTH (fpfa_pkg::SIZE_W),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (load_addr),
        .wr_data (in_size),
        .rd_en   (ram_rd_en),
        .rd_addr (raddr_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign fits = rvalid_reg && !rused_reg && (ram_rd_data >= req_size_reg);

    always_comb
    begin
        unique case (fit_policy_reg)
            fpfa_pkg::POLICY_BEST:
            begin
                take = fits && (!found_reg || (ram_rd_data < pick_size_reg));
            end
            fpfa_pkg::POLICY_WORST:
            begin
                take = fits && (!found_reg || (ram_rd_data > pick_size_reg));
            end
            default:
            begin
                take = fits && !found_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        fit_policy_next  = fit_policy_reg;
        block_count_next = block_count_reg;
        in_use_next      = in_use_reg;
        raddr_next       = raddr_reg;
        rvalid_next      = 1'b0;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        req_size_next    = req_size_reg;
        lim_next         = lim_reg;
        ridx_next        = ridx_reg;
        rused_next       = rused_reg;
        pick_next        = pick_reg;
        pick_size_next   = pick_size_reg;
        out_granted_next = out_granted_reg;
        out_index_next   = out_index_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fpfa_pkg::REG_FIT_POLICY:
                begin
                    fit_policy_next = cfg_data[fpfa_pkg::POL_W-1:0];
                end
                fpfa_pkg::REG_BLOCK_COUNT:
                begin
                    block_count_next = cfg_data[fpfa_pkg::COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (in_cmd)
                        fpfa_pkg::CMD_LOAD:
                        begin
                            if (idx_ok)
                            begin
                                in_use_next[load_addr] = 1'b0;
                            end
                        end
                        fpfa_pkg::CMD_ALLOC:
                        begin
                            req_size_next = in_size;
                            lim_next      = (32'(block_count_reg) > NUM_BLOCKS)
                                            ? CNT_W'(NUM_BLOCKS)
                                            : CNT_W'(block_count_reg);
                            raddr_next    = '0;
                            found_next    = 1'b0;
                            pick_next     = '0;
                            state_next    = ST_SCAN;
                        end
                        fpfa_pkg::CMD_CLEAR:
                        begin
                            in_use_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (ram_rd_en)
                begin
                    rvalid_next = 1'b1;
                    ridx_next   = raddr_reg[IDX_W-1:0];
                    rused_next  = in_use_reg[raddr_reg[IDX_W-1:0]];
                    raddr_next  = raddr_reg + 1'b1;
                end
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_next      = ridx_reg;
                    pick_size_next = ram_rd_data;
                end
                if (!ram_rd_en && !rvalid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = found_reg;
                    out_index_next   = found_reg ? fpfa_pkg::GIDX_W'(pick_reg) : '0;
                    if (found_reg)
                    begin
                        in_use_next[pick_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fit_policy_reg  <= fpfa_pkg::POLICY_FIRST;
            block_count_reg <= '0;
            in_use_reg      <= '0;
            raddr_reg       <= '0;
            rvalid_reg      <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fit_policy_reg  <= fit_policy_next;
            block_count_reg <= block_count_next;
            in_use_reg      <= in_use_next;
            raddr_reg       <= raddr_next;
            rvalid_reg      <= rvalid_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_size_reg    <= req_size_next;
        lim_reg         <= lim_next;
        ridx_reg        <= ridx_next;
        rused_reg       <= rused_next;
        pick_reg        <= pick_next;
        pick_size_reg   <= pick_size_next;
        out_granted_reg <= out_granted_next;
        out_index_reg   <= out_index_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_granted_reg;
    assign m_tdata  = {{(fpfa_pkg::M_TDATA_W - fpfa_pkg::GIDX_W){1'b0}}, out_index_reg};

endmodule
